### src/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_END     = 2'd2,
    FUNC_TEXT    = 2'd3
  } func_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_FULL  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       text_start;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] position;
  } rsp_t;

  typedef struct packed {
    logic push;
    rsp_t rsp;
  } push_t;

endpackage

`default_nettype wire

### src/tpm_out_stage.sv
`default_nettype none

module tpm_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tpm_pkg::push_t push_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tpm_pkg::rsp_t      out_rsp_o
);
  import tpm_pkg::*;

  logic valid_q;
  rsp_t rsp_q;

  assign full_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rsp_q   <= '0;
    end else if (push_i.push && !full_o) begin
      valid_q <= 1'b1;
      rsp_q   <= push_i.rsp;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/trie_pattern_matcher.sv
`default_nettype none
// Case-insensitive multi-pattern matcher over a trie built one request at a time.
// Input channel: in_valid_i / in_stall_o / in_req_i (func, data_byte, text_start).
//   func clear empties the trie, pattern byte extends the pattern being built,
//   end of pattern marks the cursor state accepting, text byte runs the matcher.
// Output channel: out_valid_o / out_stall_i / out_rsp_o (kind, position).
//   kind match gives the text index of the byte that ends a match; kind full
//   reports that a pattern ran out of trie states (rest of pattern dropped).
// Per request, until ready for the next: end of pattern finishes in ST_IDLE,
//   pattern byte passes ST_PAT unless dropped, text byte passes ST_TXT_EDGE
//   and, if an edge is found, ST_TXT_ACC; a response adds ST_EMIT, where it
//   waits while the output register is held by a stall. The edge table is one
//   synchronous memory with two read ports and one write port; each text byte
//   reads its own row and the root row in parallel, then the accept flag memory of the target.
// Clear and reset: a clearing pass writes every edge table entry, one per
//   cycle, MAX_STATES * 256 entries (65536 at the default). in_stall_o is high
//   during the pass. Reset clears the text position too; clear keeps it.
// A stalled response waits in the output register; a new request is still
//   taken and only a second response waits for the register to free.
module trie_pattern_matcher #(
  parameter int MAX_STATES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire tpm_pkg::req_t in_req_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output tpm_pkg::rsp_t     out_rsp_o
);
  import tpm_pkg::*;

  localparam int SW    = $clog2(MAX_STATES);
  localparam int AW    = SW + 8;
  localparam int DEPTH = MAX_STATES * 256;
  localparam logic [AW-1:0] LastAddr  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] StatesA   = AW'(MAX_STATES);
  localparam logic [SW:0]   StatesNf  = (SW + 1)'(MAX_STATES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAT,
    ST_TXT_EDGE,
    ST_TXT_ACC,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [SW-1:0] match_state_q, match_state_d;
  logic [SW-1:0] cursor_q, cursor_d;
  logic [SW:0]   next_free_q, next_free_d;
  logic          failed_q, failed_d;
  logic [31:0]   text_pos_q, text_pos_d;
  logic [31:0]   pos_q, pos_d;
  logic [7:0]    char_q, char_d;
  rsp_t          rsp_q, rsp_d;

  logic [SW-1:0] edge_mem [DEPTH];
  logic          acc_mem [MAX_STATES];
  logic [SW-1:0] edge_a_q, edge_b_q;
  logic          acc_q;

  logic          edge_we;
  logic [AW-1:0] edge_waddr, edge_raddr_a, edge_raddr_b;
  logic [SW-1:0] edge_wdata;
  logic          acc_we, acc_wdata;
  logic [SW-1:0] acc_waddr, acc_raddr;

  logic          accept;
  logic [7:0]    in_char;
  logic [SW-1:0] start_state, target;
  logic [31:0]   start_pos;
  push_t         push;
  logic          out_full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_char    = (in_req_i.data_byte >= 8'h41 && in_req_i.data_byte <= 8'h5a) ?
                      in_req_i.data_byte + 8'h20 : in_req_i.data_byte;
  assign start_state = in_req_i.text_start ? '0 : match_state_q;
  assign start_pos   = in_req_i.text_start ? '0 : text_pos_q;
  assign target      = (edge_a_q != '0) ? edge_a_q : edge_b_q;

  always_comb begin
    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    match_state_d = match_state_q;
    cursor_d      = cursor_q;
    next_free_d   = next_free_q;
    failed_d      = failed_q;
    text_pos_d    = text_pos_q;
    pos_d         = pos_q;
    char_d        = char_q;
    rsp_d         = rsp_q;
    edge_we       = 1'b0;
    edge_waddr    = {cursor_q, char_q};
    edge_wdata    = next_free_q[SW-1:0];
    edge_raddr_a  = {cursor_q, in_char};
    edge_raddr_b  = {{SW{1'b0}}, in_char};
    acc_we        = 1'b0;
    acc_waddr     = cursor_q;
    acc_wdata     = 1'b1;
    acc_raddr     = target;
    push.push     = 1'b0;
    push.rsp      = rsp_q;

    unique case (state_q)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_cnt_q;
        edge_wdata = '0;
        acc_we     = (clr_cnt_q < StatesA);
        acc_waddr  = clr_cnt_q[SW-1:0];
        acc_wdata  = 1'b0;
        clr_cnt_d  = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          char_d = in_char;
          unique case (func_e'(in_req_i.func))
            FUNC_CLEAR: begin
              clr_cnt_d     = '0;
              match_state_d = '0;
              cursor_d      = '0;
              next_free_d   = (SW + 1)'(1);
              failed_d      = 1'b0;
              state_d       = ST_CLEAR;
            end
            FUNC_PATTERN: begin
              if (!failed_q) begin
                state_d = ST_PAT;
              end
            end
            FUNC_END: begin
              acc_we   = !failed_q;
              cursor_d = '0;
              failed_d = 1'b0;
            end
            FUNC_TEXT: begin
              edge_raddr_a = {start_state, in_char};
              pos_d        = start_pos;
              text_pos_d   = (start_pos == '1) ? start_pos : start_pos + 32'd1;
              state_d      = ST_TXT_EDGE;
            end
          endcase
        end
      end
      ST_PAT: begin
        if (edge_a_q != '0) begin
          cursor_d = edge_a_q;
          state_d  = ST_IDLE;
        end else if (next_free_q < StatesNf) begin
          edge_we     = 1'b1;
          cursor_d    = next_free_q[SW-1:0];
          next_free_d = next_free_q + (SW + 1)'(1);
          state_d     = ST_IDLE;
        end else begin
          failed_d = 1'b1;
          rsp_d    = '{kind: KIND_FULL, position: '0};
          state_d  = ST_EMIT;
        end
      end
      ST_TXT_EDGE: begin
        match_state_d = target;
        state_d       = (target != '0) ? ST_TXT_ACC : ST_IDLE;
      end
      ST_TXT_ACC: begin
        if (acc_q) begin
          rsp_d   = '{kind: KIND_MATCH, position: pos_q};
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        push.push = 1'b1;
        if (!out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      match_state_q <= '0;
      cursor_q      <= '0;
      next_free_q   <= (SW + 1)'(1);
      failed_q      <= 1'b0;
      text_pos_q    <= '0;
      pos_q         <= '0;
      char_q        <= '0;
      rsp_q         <= '0;
    end else begin
      state_q       <= state_d;
      clr_cnt_q     <= clr_cnt_d;
      match_state_q <= match_state_d;
      cursor_q      <= cursor_d;
      next_free_q   <= next_free_d;
      failed_q      <= failed_d;
      text_pos_q    <= text_pos_d;
      pos_q         <= pos_d;
      char_q        <= char_d;
      rsp_q         <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_a_q <= edge_mem[edge_raddr_a];
    edge_b_q <= edge_mem[edge_raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  tpm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (out_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_next_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_free_q != '0) && (next_free_q <= StatesNf))
    else $error("next free state out of range");

  a_cursor_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_q} < next_free_q))
    else $error("build cursor beyond allocated states");

  a_match_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, match_state_q} < next_free_q))
    else $error("match state beyond allocated states");

  a_no_push_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !push.push && !edge_we || (edge_wdata == '0))
    else $error("clearing pass disturbed");

endmodule

`default_nettype wire

### bench/trie_match_checker.sv
`timescale 1ns / 1ps

module trie_match_checker #(
  parameter int MAX_STATES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire tpm_pkg::req_t in_req_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire tpm_pkg::rsp_t out_rsp_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 match_count_o,
  output int                 full_count_o
);

  import tpm_pkg::*;

  localparam int SHOWN_FAILS = 10;

  // edge target 0 means no edge; nothing ever points back to the root
  logic [15:0] edge_to [MAX_STATES * 256];
  bit          accept_at [MAX_STATES];
  int unsigned walk_state;
  int unsigned cursor_state;
  int unsigned free_state;
  bit          build_dead;
  logic [31:0] text_pos;
  rsp_t        due_rsp [$];

  function automatic void wipe_trie();
    foreach (edge_to[i]) edge_to[i] = '0;
    foreach (accept_at[i]) accept_at[i] = 1'b0;
    walk_state   = 0;
    cursor_state = 0;
    free_state   = 1;
    build_dead   = 1'b0;
  endfunction

  function automatic bit predict_request(input req_t r, output rsp_t rsp);
    logic [7:0]  ch;
    int unsigned slot;
    logic [15:0] hop;
    ch = r.data_byte;
    if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
    rsp = '0;
    case (func_e'(r.func))
      FUNC_CLEAR: wipe_trie();
      FUNC_PATTERN: begin
        if (!build_dead) begin
          slot = cursor_state * 256 + ch;
          if (edge_to[slot] != 0) begin
            cursor_state = 32'(edge_to[slot]);
          end else if (free_state < MAX_STATES) begin
            edge_to[slot] = 16'(free_state);
            cursor_state  = free_state;
            free_state++;
          end else begin
            build_dead = 1'b1;
            rsp.kind   = KIND_FULL;
            return 1'b1;
          end
        end
      end
      FUNC_END: begin
        if (!build_dead) accept_at[cursor_state] = 1'b1;
        cursor_state = 0;
        build_dead   = 1'b0;
      end
      FUNC_TEXT: begin
        if (r.text_start) begin
          walk_state = 0;
          text_pos   = '0;
        end
        rsp.position = text_pos;
        if (text_pos != '1) text_pos++;
        hop = edge_to[walk_state * 256 + ch];
        // no edge: retry the same byte from the root
        if (hop == 0) hop = edge_to[ch];
        walk_state = 32'(hop);
        if (hop != 0 && accept_at[hop]) begin
          rsp.kind = KIND_MATCH;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      wipe_trie();
      text_pos = '0;
      due_rsp.delete();
      fail_count_o  = 0;
      match_count_o = 0;
      full_count_o  = 0;
    end else begin
      if (in_valid_i && !in_stall_i && predict_request(in_req_i, want)) begin
        due_rsp = {due_rsp, want};
      end
      if (out_valid_i && !out_stall_i) begin
        if (out_rsp_i.kind == KIND_FULL) full_count_o++;
        else match_count_o++;
        if (due_rsp.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= SHOWN_FAILS) begin
            $display("%0t: unexpected response kind %0d position %0d", $realtime,
                     out_rsp_i.kind, out_rsp_i.position);
          end
        end else begin
          want = due_rsp.pop_front();
          if (out_rsp_i.kind !== want.kind || out_rsp_i.position !== want.position) begin
            fail_count_o++;
            if (fail_count_o <= SHOWN_FAILS) begin
              $display("%0t: expected kind %0d position %0d, got kind %0d position %0d",
                       $realtime, want.kind, want.position, out_rsp_i.kind,
                       out_rsp_i.position);
            end
          end
        end
      end
    end
    pending_o = due_rsp.size();
  end

endmodule

### bench/trie_pattern_matcher_test.sv
`timescale 1ns / 1ps

module trie_pattern_matcher_test;

  import tpm_pkg::*;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 400;

  logic clk;
  logic rst_n;
  logic src_valid;
  logic src_stall;
  req_t src_req;
  logic snk_valid;
  logic snk_stall;
  rsp_t snk_rsp;

  int fail_count;
  int pending;
  int match_count;
  int full_count;

  int sent;
  int clears;
  int idle_cycles;
  bit rush;
  bit snk_rush;
  bit hold_req;
  bit hold_done;

  trie_pattern_matcher u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (src_valid),
    .in_stall_o (src_stall),
    .in_req_i   (src_req),
    .out_valid_o(snk_valid),
    .out_stall_i(snk_stall),
    .out_rsp_o  (snk_rsp)
  );

  trie_match_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (src_valid),
    .in_stall_i   (src_stall),
    .in_req_i     (src_req),
    .out_valid_i  (snk_valid),
    .out_stall_i  (snk_stall),
    .out_rsp_i    (snk_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .match_count_o(match_count),
    .full_count_o (full_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (src_valid && !src_stall) || (snk_valid && !snk_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or response moved for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // small mixed-case alphabet so that patterns share prefixes and text hits them
  function automatic logic [7:0] pick_char(input bit any_byte);
    logic [7:0] ch;
    ch = 8'h61 + 8'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) ch = ch - 8'h20;
    if (any_byte || $urandom_range(0, 15) == 0) ch = 8'($urandom);
    return ch;
  endfunction

  task automatic send_req(input func_e f, input logic [7:0] b, input logic st);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_req   <= '{func: f, data_byte: b, text_start: st};
    do @(posedge clk); while (src_stall);
    sent++;
    if (f == FUNC_CLEAR) clears++;
  endtask

  task automatic send_word(input int len, input bit any_byte, input bit closed);
    repeat (len) send_req(FUNC_PATTERN, pick_char(any_byte), 1'($urandom));
    if (closed) send_req(FUNC_END, 8'($urandom), 1'($urandom));
  endtask

  task automatic scan_text(input int len, input bit fresh);
    for (int i = 0; i < len; i++) begin
      send_req(FUNC_TEXT, pick_char(1'b0),
               (i == 0 && fresh) || $urandom_range(0, 31) == 0);
    end
  endtask

  initial begin
    src_valid = 1'b0;
    src_req   = '0;
    rush      = 1'b0;
    hold_req  = 1'b0;
    sent      = 0;
    clears    = 0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // response side: random stalls per response, one long hold on request
  initial begin
    int gap;
    snk_stall = 1'b0;
    snk_rush  = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          snk_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 29) == 0) snk_rush = ~snk_rush;
      gap = snk_rush ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
        @(negedge clk);
        snk_stall <= 1'b1;
      end
      @(negedge clk);
      snk_stall <= 1'b0;
      do @(posedge clk); while (!(snk_valid && !snk_stall));
    end
  end

  initial begin
    int first_random;
    int sel;
    int spare_clears;
    bit filled;
    @(posedge rst_n);

    // empty trie, then case folding, byte extremes, empty pattern, text restart, clear
    send_req(FUNC_TEXT, 8'h61, 1'b1);
    send_req(FUNC_PATTERN, 8'h41, 1'b0);
    send_req(FUNC_PATTERN, 8'h62, 1'b0);
    send_req(FUNC_END, 8'h00, 1'b0);
    send_req(FUNC_PATTERN, 8'hFF, 1'b0);
    send_req(FUNC_END, 8'hFF, 1'b1);
    send_req(FUNC_END, 8'h00, 1'b0);
    send_req(FUNC_PATTERN, 8'h5A, 1'b0);
    send_req(FUNC_END, 8'h00, 1'b0);
    send_req(FUNC_PATTERN, 8'h40, 1'b1);
    send_req(FUNC_PATTERN, 8'h5B, 1'b0);
    send_req(FUNC_END, 8'h00, 1'b0);
    send_req(FUNC_TEXT, 8'h61, 1'b1);
    send_req(FUNC_TEXT, 8'h42, 1'b0);
    send_req(FUNC_TEXT, 8'hFF, 1'b0);
    send_req(FUNC_TEXT, 8'h7A, 1'b0);
    send_req(FUNC_TEXT, 8'h40, 1'b0);
    send_req(FUNC_TEXT, 8'h5B, 1'b0);
    send_req(FUNC_TEXT, 8'h60, 1'b0);
    send_req(FUNC_TEXT, 8'h00, 1'b1);
    send_req(FUNC_TEXT, 8'h5A, 1'b0);
    send_req(FUNC_CLEAR, 8'hFF, 1'b1);
    send_req(FUNC_TEXT, 8'h7A, 1'b0);

    first_random = sent;

    // every text byte matches while the response side holds off
    send_req(FUNC_PATTERN, 8'h51, 1'b0);
    send_req(FUNC_END, 8'h00, 1'b0);
    rush     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_req(FUNC_TEXT, $urandom_range(0, 1) ? 8'h71 : 8'h51, i == 0);
    end

    filled       = 1'b0;
    spare_clears = 2;
    while (sent < first_random + RANDOM_ITEMS) begin
      sel  = $urandom_range(0, 99);
      rush = $urandom_range(0, 3) == 0;
      if (!filled && sent > first_random + 450) begin
        // run the table out of states, keep building on the full table
        filled = 1'b1;
        repeat (14) send_word(20, 1'b1, 1'b1);
        repeat (3) send_word($urandom_range(1, 4), 1'b0, 1'b1);
        scan_text($urandom_range(10, 30), 1'b1);
        send_req(FUNC_CLEAR, 8'($urandom), 1'($urandom));
      end else if (sel < 3 && spare_clears > 0) begin
        spare_clears--;
        send_req(FUNC_CLEAR, 8'($urandom), 1'($urandom));
      end else if (sel < 20) begin
        repeat ($urandom_range(4, 12)) begin
          send_req(func_e'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_word($urandom_range(1, 4), 1'b0, $urandom_range(0, 7) != 0);
        end
        scan_text($urandom_range(8, 40), $urandom_range(0, 5) != 0);
      end
    end

    @(negedge clk);
    src_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests with %0d trie clears; %0d match and %0d table-full responses",
             sent, clears, match_count, full_count);
    $display("checked, including a %0d-cycle output hold with requests still offered.",
             LONG_HOLD);
    if (pending != 0) $display("%0d expected responses never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
